// File: sv/rhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared widths, constants and the item record carried along the divider row.
// ----------------------------------------------------------------------------
package rhp_pkg;

	localparam int CHAN_W  = 8;
	localparam int HUE_W   = 13;
	localparam int SAT_W   = 8;
	localparam int REM_W   = 21;
	localparam int NUM_W   = 22;
	localparam int N_CELLS = HUE_W;

	localparam int HUE_SECTOR = 960;
	localparam int HUE_TURN   = 5760;
	localparam int SAT_SCALE  = 255;

	typedef struct packed {
		logic [REM_W-1:0]  hue_rem;
		logic [REM_W-1:0]  sat_rem;
		logic [CHAN_W-1:0] div;
		logic [CHAN_W-1:0] brightness;
		logic [HUE_W-1:0]  hue_q;
		logic [HUE_W-1:0]  sat_q;
		logic              achromatic;
	} rhp_item_t;

endpackage

// File: sv/rgb_to_hsv_pixel_top.sv
`timescale 1ns / 1ps
// each accepted pixel passes the front stage and then the 13 divider cells before its result appears
// one pixel per clock while m_tready does not hold the row back; each cell settles one hue and one saturation bit
// the 13-cell restoring divider row sets the latency
// every stage has its own handshake, so bubbles close up under backpressure
// reset clears all stage valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// Pixel stream RGB to HSV converter: hue in 1/16 degree, saturation, value.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // hue[12:0], saturation[20:13], brightness[28:21],
	                              // achromatic[29], zero[31:30]
);
	import rhp_pkg::*;

	logic      valid [N_CELLS+1];
	logic      ready [N_CELLS+1];
	rhp_item_t item  [N_CELLS+1];
	rhp_item_t last_item;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;

	rhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_item  (item[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		rhp_div_cell #(
			.SHIFT (N_CELLS - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_ready  (ready[i]),
			.in_item   (item[i]),
			.out_valid (valid[i+1]),
			.out_ready (ready[i+1]),
			.out_item  (item[i+1])
		);
	end

	assign last_item        = item[N_CELLS];
	assign ready[N_CELLS]   = m_tready;
	assign m_tvalid         = valid[N_CELLS];
	assign hue              = last_item.achromatic ? '0 : last_item.hue_q;
	assign saturation       = last_item.achromatic ? '0 : last_item.sat_q[SAT_W-1:0];
	assign m_tdata          = {2'b00, last_item.achromatic, last_item.brightness,
	                           saturation, hue};

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !last_item.achromatic |-> hue < HUE_W'(HUE_TURN))
		else $error("hue out of range");

	a_sat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !last_item.achromatic |-> saturation != '0)
		else $error("chromatic pixel with zero saturation");

	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !last_item.achromatic |->
			last_item.hue_rem < REM_W'(last_item.div))
		else $error("hue remainder not below divisor");

	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !last_item.achromatic |->
			last_item.sat_rem < REM_W'(last_item.brightness))
		else $error("saturation remainder not below divisor");

endmodule

// File: sv/rhp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_front
// Finds max, min and sector of a pixel and forms the hue and saturation
// dividends for the divider row.
// ----------------------------------------------------------------------------
module rhp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rhp_pkg::CHAN_W-1:0]        red,
	input  logic [rhp_pkg::CHAN_W-1:0]        green,
	input  logic [rhp_pkg::CHAN_W-1:0]        blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rhp_pkg::rhp_item_t                out_item
);
	import rhp_pkg::*;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	localparam logic signed [NUM_W-1:0] SectorK = NUM_W'(HUE_SECTOR);
	localparam logic signed [NUM_W-1:0] TurnK   = NUM_W'(HUE_TURN);

	logic [CHAN_W-1:0]        hi;
	logic [CHAN_W-1:0]        lo;
	logic [CHAN_W-1:0]        d;
	sector_t                  sector;
	logic signed [NUM_W-1:0]  r_s;
	logic signed [NUM_W-1:0]  g_s;
	logic signed [NUM_W-1:0]  b_s;
	logic signed [NUM_W-1:0]  d_s;
	logic signed [NUM_W-1:0]  base;
	logic signed [NUM_W-1:0]  diff;
	logic signed [NUM_W-1:0]  num;
	logic signed [NUM_W-1:0]  num_wrap;
	rhp_item_t                item_d;
	rhp_item_t                item_s1;
	logic                     valid_s1;

	always_comb begin
		priority if (red >= green && red >= blue) begin
			sector = SECT_RED;
			hi     = red;
		end else if (green >= blue) begin
			sector = SECT_GREEN;
			hi     = green;
		end else begin
			sector = SECT_BLUE;
			hi     = blue;
		end
		lo = (red < green) ? red : green;
		lo = (lo < blue) ? lo : blue;
		d  = hi - lo;

		r_s = signed'(NUM_W'(red));
		g_s = signed'(NUM_W'(green));
		b_s = signed'(NUM_W'(blue));
		d_s = signed'(NUM_W'(d));

		unique case (sector)
			SECT_RED: begin
				base = '0;
				diff = g_s - b_s;
			end
			SECT_GREEN: begin
				base = NUM_W'(2) * SectorK * d_s;
				diff = b_s - r_s;
			end
			SECT_BLUE: begin
				base = NUM_W'(4) * SectorK * d_s;
				diff = r_s - g_s;
			end
			default: begin
				base = '0;
				diff = '0;
			end
		endcase

		num      = base + SectorK * diff;
		num_wrap = num[NUM_W-1] ? (num + TurnK * d_s) : num;

		item_d.hue_rem    = REM_W'(num_wrap);
		item_d.sat_rem    = REM_W'(d) * REM_W'(SAT_SCALE);
		item_d.div        = d;
		item_d.brightness = hi;
		item_d.hue_q      = '0;
		item_d.sat_q      = '0;
		item_d.achromatic = (d == '0);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// File: sv/rhp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_div_cell
// One restoring division step for both hue and saturation: settles one
// quotient bit of each and passes the request to the next cell.
// ----------------------------------------------------------------------------
module rhp_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rhp_pkg::rhp_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output rhp_pkg::rhp_item_t out_item
);
	import rhp_pkg::*;

	logic [REM_W-1:0] hue_trial;
	logic [REM_W-1:0] sat_trial;
	rhp_item_t        item_d;
	rhp_item_t        item_q;
	logic             valid_q;

	always_comb begin
		item_d    = in_item;
		hue_trial = REM_W'(in_item.div) << SHIFT;
		sat_trial = REM_W'(in_item.brightness) << SHIFT;
		if (in_item.hue_rem >= hue_trial) begin
			item_d.hue_rem      = in_item.hue_rem - hue_trial;
			item_d.hue_q[SHIFT] = 1'b1;
		end
		if (in_item.sat_rem >= sat_trial) begin
			item_d.sat_rem      = in_item.sat_rem - sat_trial;
			item_d.sat_q[SHIFT] = 1'b1;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
